[rtl/dq_pkg.sv]
// Shared constants, opcodes and control types of the double-ended queue.
`default_nettype none

package dq_pkg;

  // Storage geometry
  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = ADDR_W + 1;

  // Port field widths
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int REPLY_W = 32;
  localparam int WIDE_W  = 64;

  // Command opcodes
  localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_TAIL  = 3'd3;
  localparam logic [OP_W-1:0] OP_SIZE      = 3'd4;
  localparam logic [OP_W-1:0] OP_EMPTY     = 3'd5;
  localparam logic [OP_W-1:0] OP_FRONT     = 3'd6;
  localparam logic [OP_W-1:0] OP_BACK      = 3'd7;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted command
    logic exec;    // carry out the captured command
    logic finish;  // deliver the word read from the store
  } dq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mem_read;  // captured command reads a stored word
  } dq_sts_t;

endpackage

`default_nettype wire

[rtl/dq_ctrl.sv]
// Controller state machine: sequences capture, execute and store read.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire dq_sts_t sts,
  output dq_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Pick the next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = sts.mem_read ? ST_WAIT : ST_IDLE;
      end
      ST_WAIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Drive commands and busy
  always_comb begin
    busy       = (state_r != ST_IDLE);
    cmd.load   = start && (state_r == ST_IDLE);
    cmd.exec   = (state_r == ST_EXEC);
    cmd.finish = (state_r == ST_WAIT);
  end

endmodule

`default_nettype wire

[rtl/dq_datapath.sv]
// Datapath: ring store, head pointer, element count and result registers.
`default_nettype none

module dq_datapath
  import dq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dq_cmd_t            cmd,
  output dq_sts_t                 sts,
  input  wire logic [OP_W-1:0]    in_opcode,
  input  wire logic [VALUE_W-1:0] in_push_value,
  output logic                    out_valid,
  output logic [REPLY_W-1:0]      out_reply_value,
  output logic                    out_no_element,
  output logic                    out_push_refused
);

  // Captured command
  logic [OP_W-1:0]       op_r;
  logic [DATA_WIDTH-1:0] word_r;

  // Ring state
  logic [ADDR_W-1:0] head_r;
  logic [ADDR_W-1:0] head_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  // Store and its read port
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;

  // Result registers
  logic                  valid_r;
  logic                  valid_nxt;
  logic [REPLY_W-1:0]    reply_r;
  logic [REPLY_W-1:0]    reply_nxt;
  logic                  none_r;
  logic                  none_nxt;
  logic                  refused_r;
  logic                  refused_nxt;

  // Ring arithmetic
  logic                  is_full;
  logic                  is_empty;
  logic                  is_read_op;
  logic [ADDR_W-1:0]     head_dec;
  logic [ADDR_W-1:0]     head_inc;
  logic [SUM_W-1:0]      tail_sum;
  logic [ADDR_W-1:0]     tail_pos;
  logic [SUM_W-1:0]      back_sum;
  logic [ADDR_W-1:0]     back_pos;
  logic [WIDE_W-1:0]     in_wide;
  logic [WIDE_W-1:0]     rd_wide;
  logic [WIDE_W-1:0]     cnt_wide;

  // Capture the command on transfer; mask the word to the store width
  assign in_wide = WIDE_W'(in_push_value);
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      word_r <= in_wide[DATA_WIDTH-1:0];
    end
  end

  // Decode status of the ring
  assign is_full    = (count_r == CNT_W'(DEPTH));
  assign is_empty   = (count_r == '0);
  assign is_read_op = op_r inside {OP_POP_HEAD, OP_POP_TAIL, OP_FRONT, OP_BACK};
  assign sts.mem_read = is_read_op && !is_empty;

  // Wrap positions around the ring
  assign head_dec = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_pos = (tail_sum >= SUM_W'(DEPTH)) ? ADDR_W'(tail_sum - SUM_W'(DEPTH))
                                                : tail_sum[ADDR_W-1:0];
  assign back_sum = SUM_W'(head_r) + SUM_W'(count_r - 1'b1);
  assign back_pos = (back_sum >= SUM_W'(DEPTH)) ? ADDR_W'(back_sum - SUM_W'(DEPTH))
                                                : back_sum[ADDR_W-1:0];

  assign rd_wide  = WIDE_W'(rd_data_r);
  assign cnt_wide = WIDE_W'(count_r);

  // Execute the captured command
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    wr_en       = 1'b0;
    wr_addr     = tail_pos;
    rd_en       = 1'b0;
    rd_addr     = head_r;
    valid_nxt   = 1'b0;
    reply_nxt   = reply_r;
    none_nxt    = none_r;
    refused_nxt = refused_r;
    if (cmd.exec) begin
      case (op_r)
        OP_PUSH_HEAD, OP_PUSH_TAIL: begin
          if (is_full) begin
            valid_nxt   = 1'b1;
            reply_nxt   = '0;
            none_nxt    = 1'b0;
            refused_nxt = 1'b1;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            if (op_r == OP_PUSH_HEAD) begin
              head_nxt = head_dec;
              wr_addr  = head_dec;
            end
          end
        end
        OP_POP_HEAD, OP_POP_TAIL, OP_FRONT, OP_BACK: begin
          if (is_empty) begin
            valid_nxt   = 1'b1;
            reply_nxt   = '0;
            none_nxt    = 1'b1;
            refused_nxt = 1'b0;
          end else begin
            rd_en = 1'b1;
            if (op_r == OP_POP_TAIL || op_r == OP_BACK) rd_addr = back_pos;
            if (op_r == OP_POP_HEAD) head_nxt = head_inc;
            if (op_r == OP_POP_HEAD || op_r == OP_POP_TAIL) count_nxt = count_r - 1'b1;
          end
        end
        OP_SIZE: begin
          valid_nxt   = 1'b1;
          reply_nxt   = cnt_wide[REPLY_W-1:0];
          none_nxt    = 1'b0;
          refused_nxt = 1'b0;
        end
        OP_EMPTY: begin
          valid_nxt   = 1'b1;
          reply_nxt   = REPLY_W'(is_empty);
          none_nxt    = 1'b0;
          refused_nxt = 1'b0;
        end
        default: begin
          valid_nxt = 1'b0;
        end
      endcase
    end else if (cmd.finish) begin
      // Deliver the word read in the previous cycle
      valid_nxt   = 1'b1;
      reply_nxt   = rd_wide[REPLY_W-1:0];
      none_nxt    = 1'b0;
      refused_nxt = 1'b0;
    end
  end

  // Write and read the store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= word_r;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Hold ring pointers and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reply_r   <= reply_nxt;
    none_r    <= none_nxt;
    refused_r <= refused_nxt;
  end

  assign out_valid        = valid_r;
  assign out_reply_value  = reply_r;
  assign out_no_element   = none_r;
  assign out_push_refused = refused_r;

endmodule

`default_nettype wire

[rtl/double_ended_queue.sv]
// Top level of the double-ended queue: controller plus datapath.
//
//   channel   ports                                   transfer
//   command   start, busy, in_opcode, in_push_value   start && !busy
//   result    out_valid, out_reply_value,             out_valid (one cycle)
//             out_no_element, out_push_refused
//
// A push, size or empty command, or a pop or peek on an empty queue, goes from
// execute back to idle; pops and peeks on a non-empty queue also pass a wait
// state, set by the registered read port of the ring store. A result (none for
// an accepted push) shows in the cycle after its command's execute cycle (after
// the wait state for pops and peeks on a non-empty queue); it holds for one cycle.
// Reset clears the head pointer and count; the store is not cleared.
// The result side cannot stall; the command side waits while busy is high.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [OP_W-1:0]    in_opcode,
  input  wire logic [VALUE_W-1:0] in_push_value,
  output logic                    out_valid,
  output logic [REPLY_W-1:0]      out_reply_value,
  output logic                    out_no_element,
  output logic                    out_push_refused
);

  dq_cmd_t cmd;
  dq_sts_t sts;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  dq_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_reply_value  (out_reply_value),
    .out_no_element   (out_no_element),
    .out_push_refused (out_push_refused)
  );

endmodule

`default_nettype wire

[rtl/dq_checker.sv]
// Port-level checks of the double-ended queue, bound to the top level.
`default_nettype none

module dq_checker
  import dq_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [OP_W-1:0]    in_opcode,
  input wire logic               out_valid,
  input wire logic [REPLY_W-1:0] out_reply_value,
  input wire logic               out_no_element,
  input wire logic               out_push_refused
);

  logic xfer;
  assign xfer = start && !busy;

  // A transfer always starts work
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> busy)
    else $error("busy not raised after command transfer");

  // Flags are exclusive and carry a zero reply
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_no_element && out_push_refused))
    else $error("no_element and push_refused both set");

  a_flag_zero_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_no_element || out_push_refused)) |-> (out_reply_value == '0))
    else $error("flagged result carries a nonzero reply");

  // Size and empty always give a result, from the result register after execute
  a_status_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && (in_opcode == OP_SIZE || in_opcode == OP_EMPTY)) |-> ##2 out_valid)
    else $error("size or empty command gave no result");

  // Empty query answers 0 or 1
  a_empty_bool: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && in_opcode == OP_EMPTY) |-> ##2 (out_reply_value[REPLY_W-1:1] == '0))
    else $error("empty query reply is not 0 or 1");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_opcode        (in_opcode),
  .out_valid        (out_valid),
  .out_reply_value  (out_reply_value),
  .out_no_element   (out_no_element),
  .out_push_refused (out_push_refused)
);

`default_nettype wire

[bench/double_ended_queue_test.sv]
// Self-checking testbench for the double-ended queue command engine.
`timescale 1ns / 100ps

module double_ended_queue_test;
  import dq_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 10;
  localparam int MAX_GAP       = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int MIXED_ITEMS   = 250;
  localparam int EXTRA_AT_EDGE = 10;

  localparam logic [OP_W-1:0] ALL_OPS [8] = '{
    OP_PUSH_HEAD, OP_PUSH_TAIL, OP_POP_HEAD, OP_POP_TAIL,
    OP_SIZE, OP_EMPTY, OP_FRONT, OP_BACK
  };
  localparam logic [OP_W-1:0] QUERY_OPS [4] = '{OP_SIZE, OP_EMPTY, OP_FRONT, OP_BACK};

  typedef struct packed {
    logic [REPLY_W-1:0] reply_value;
    logic               no_element;
    logic               push_refused;
  } reply_t;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 start         = 1'b0;
  logic [OP_W-1:0]      in_opcode     = OP_SIZE;
  logic [VALUE_W-1:0]   in_push_value = '0;
  logic                 busy;
  logic                 out_valid;
  logic [REPLY_W-1:0]   out_reply_value;
  logic                 out_no_element;
  logic                 out_push_refused;

  // Mirror of the queue contents
  logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
  logic [ADDR_W-1:0]     ring_head  = '0;
  logic [CNT_W-1:0]      ring_count = '0;

  reply_t pending_replies [$];
  int     err_count   = 0;
  int     idle_cycles = 0;
  int     burst_left  = 0;

  double_ended_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_reply_value  (out_reply_value),
    .out_no_element   (out_no_element),
    .out_push_refused (out_push_refused)
  );

  always #HALF_PERIOD clk = ~clk;

  // Append one expected reply behind the others
  task automatic expect_reply(input reply_t r);
    pending_replies = {pending_replies, r};
  endtask

  // Update the mirror for one accepted command and queue its reply, if any
  task automatic apply_command(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
    reply_t            r;
    logic [ADDR_W-1:0] pos;
    logic              is_full;
    logic              is_empty;
    r        = '0;
    is_full  = (ring_count == CNT_W'(DEPTH));
    is_empty = (ring_count == '0);
    case (op)
      OP_PUSH_HEAD, OP_PUSH_TAIL: begin
        if (is_full) begin
          r.push_refused = 1'b1;
          expect_reply(r);
        end else if (op == OP_PUSH_HEAD) begin
          ring_head           = ADDR_W'((int'(ring_head) + DEPTH - 1) % DEPTH);
          ring_mem[ring_head] = DATA_WIDTH'(value);
          ring_count          = ring_count + 1'b1;
        end else begin
          pos           = ADDR_W'((int'(ring_head) + int'(ring_count)) % DEPTH);
          ring_mem[pos] = DATA_WIDTH'(value);
          ring_count    = ring_count + 1'b1;
        end
      end
      OP_POP_HEAD, OP_POP_TAIL, OP_FRONT, OP_BACK: begin
        if (is_empty) begin
          r.no_element = 1'b1;
        end else begin
          if (op == OP_POP_HEAD || op == OP_FRONT) pos = ring_head;
          else pos = ADDR_W'((int'(ring_head) + int'(ring_count) - 1) % DEPTH);
          r.reply_value = REPLY_W'(ring_mem[pos]);
          if (op == OP_POP_HEAD) begin
            ring_head  = ADDR_W'((int'(ring_head) + 1) % DEPTH);
            ring_count = ring_count - 1'b1;
          end else if (op == OP_POP_TAIL) begin
            ring_count = ring_count - 1'b1;
          end
        end
        expect_reply(r);
      end
      OP_SIZE: begin
        r.reply_value = REPLY_W'(ring_count);
        expect_reply(r);
      end
      default: begin
        r.reply_value = REPLY_W'(is_empty);
        expect_reply(r);
      end
    endcase
  endtask

  // Send one command, idling a random number of cycles first
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(20, 60);
      gap        = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
    // start stays high from the previous transfer only when there is no gap
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_opcode     <= op;
    in_push_value <= value;
    do @(posedge clk); while (busy);
    apply_command(op, value);
  endtask

  // Hold off the sender until every queued reply has come back
  task automatic wait_all_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Empty-queue pops and peeks, extreme words at both ends, every opcode
  task automatic test_directed();
    send_cmd(OP_POP_HEAD, '0);
    send_cmd(OP_POP_TAIL, '1);
    send_cmd(OP_FRONT, '0);
    send_cmd(OP_BACK, '0);
    send_cmd(OP_SIZE, '0);
    send_cmd(OP_EMPTY, '0);
    send_cmd(OP_PUSH_TAIL, '0);
    send_cmd(OP_PUSH_HEAD, '1);
    send_cmd(OP_PUSH_TAIL, 32'hAAAA_AAAA);
    send_cmd(OP_PUSH_HEAD, 32'h5555_5555);
    send_cmd(OP_SIZE, '0);
    send_cmd(OP_EMPTY, '0);
    send_cmd(OP_FRONT, '0);
    send_cmd(OP_BACK, '0);
    send_cmd(OP_POP_TAIL, '0);
    send_cmd(OP_POP_HEAD, '0);
    send_cmd(OP_POP_HEAD, '0);
    send_cmd(OP_POP_TAIL, '0);
    send_cmd(OP_POP_TAIL, '0);
    send_cmd(OP_FRONT, '0);
    send_cmd(OP_SIZE, '0);
    send_cmd(OP_EMPTY, '0);
  endtask

  // Uniform opcodes keep the queue near empty and wrap the head both ways
  task automatic test_mixed_random();
    for (int i = 0; i < MIXED_ITEMS; i++) begin
      send_cmd(ALL_OPS[$urandom_range(0, 7)], random_word());
    end
  endtask

  // Push until full, then check that further pushes are refused
  task automatic test_fill_to_full();
    while (ring_count != CNT_W'(DEPTH)) begin
      if ($urandom_range(0, 9) != 0)
        send_cmd($urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD, random_word());
      else
        send_cmd(QUERY_OPS[$urandom_range(0, 3)], random_word());
    end
    for (int i = 0; i < EXTRA_AT_EDGE; i++) begin
      if ($urandom_range(0, 2) != 0)
        send_cmd($urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD, random_word());
      else
        send_cmd(QUERY_OPS[$urandom_range(0, 3)], random_word());
    end
  endtask

  // Pop from both ends until empty, then pop and peek past the bottom
  task automatic test_drain_to_empty();
    while (ring_count != '0) begin
      if ($urandom_range(0, 9) != 0)
        send_cmd($urandom_range(0, 1) ? OP_POP_TAIL : OP_POP_HEAD, random_word());
      else
        send_cmd(QUERY_OPS[$urandom_range(0, 3)], random_word());
    end
    for (int i = 0; i < EXTRA_AT_EDGE; i++) begin
      send_cmd(ALL_OPS[$urandom_range(2, 7)], random_word());
    end
  endtask

  // Compare each reply with the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        err_count <= err_count + 1;
        if (err_count < MAX_REPORTS)
          $display("unexpected reply: value=%h no_element=%b push_refused=%b",
                   out_reply_value, out_no_element, out_push_refused);
      end else begin
        want = pending_replies[0];
        pending_replies.delete(0);
        if (out_reply_value !== want.reply_value || out_no_element !== want.no_element ||
            out_push_refused !== want.push_refused) begin
          err_count <= err_count + 1;
          if (err_count < MAX_REPORTS)
            $display("reply mismatch: expected %h/%b/%b, got %h/%b/%b",
                     want.reply_value, want.no_element, want.push_refused,
                     out_reply_value, out_no_element, out_push_refused);
        end
      end
    end
  end

  // End the run when neither a transfer nor a result happens for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_all_replies();
    test_mixed_random();
    wait_all_replies();
    test_fill_to_full();
    wait_all_replies();
    test_drain_to_empty();
    wait_all_replies();
    if (err_count == 0 && pending_replies.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dq_pkg.sv
rtl/dq_ctrl.sv
rtl/dq_datapath.sv
rtl/double_ended_queue.sv
rtl/dq_checker.sv
bench/double_ended_queue_test.sv
